@@ rtl/svu_pkg.sv @@
// Shared types, constants and step functions for the sky cloud vertex UV unit.
// Depends on nothing; used by svu_cell, svu_chain and the top level.
package svu_pkg;

    localparam int NUM_W = 48;
    localparam int DEN_W = 16;
    localparam int LANES = 4;
    localparam int STEPS = 48;

    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_ALTITUDE = 2'd1;
    localparam logic [1:0] REG_TILE_W   = 2'd2;
    localparam logic [1:0] REG_TILE_H   = 2'd3;

    localparam logic [31:0] MIN_RISE    = 32'd1600;
    localparam logic [14:0] MIN_DIR_Y   = 15'd16;
    localparam logic [36:0] REACH_LIMIT = 37'd78643200000;
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [4:0]  ROOT_STEPS  = 5'd16;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [NUM_W-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic [4:0]  cnt;
        logic [31:0] val;
        logic [16:0] rem;
        logic [15:0] root;
    } root_lane_t;

    typedef struct packed {
        logic               active;
        logic signed [15:0] dx;
        logic signed [15:0] dz;
        logic signed [15:0] dyr;
        logic               ex_neg;
        logic [9:0]         ex_lo;
        logic               ez_neg;
        logic [9:0]         ez_lo;
        logic [18:0]        t15_lo;
    } side1_t;

    typedef struct packed {
        logic               active;
        logic signed [15:0] dx;
        logic signed [15:0] dz;
        logic signed [15:0] dyr;
        logic [15:0]        h;
        logic [42:0]        d;
        logic signed [24:0] rs;
        logic signed [24:0] rz;
        logic [29:0]        rt;
    } side2_t;

    typedef struct packed {
        logic        active;
        logic [16:0] op;
        logic        s_neg;
        logic        t_neg;
    } side3_t;

    localparam int SIDE_W = $bits(side2_t);

    typedef struct packed {
        logic                   valid;
        div_lane_t [LANES-1:0]  lane;
        root_lane_t             rt;
        logic [SIDE_W-1:0]      side;
    } bundle_t;

    // one restoring division step: one quotient bit
    function automatic div_lane_t div_step(div_lane_t a);
        div_lane_t      r;
        logic [DEN_W:0] sh;
        logic [DEN_W:0] diff;
        r = a;
        sh = {a.rem, a.num[NUM_W-1]};
        diff = sh - {1'b0, a.den};
        r.num = {a.num[NUM_W-2:0], 1'b0};
        if (sh >= {1'b0, a.den})
        begin
            r.rem = diff[DEN_W-1:0];
            r.quo = {a.quo[NUM_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = sh[DEN_W-1:0];
            r.quo = {a.quo[NUM_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // one digit of the integer square root, two radicand bits per step
    function automatic root_lane_t root_step(root_lane_t a);
        root_lane_t  r;
        logic [18:0] sh;
        logic [18:0] trial;
        logic [18:0] diff;
        r = a;
        sh = {a.rem, a.val[31:30]};
        trial = {1'b0, a.root, 2'b01};
        diff = sh - trial;
        if (a.cnt != 5'd0)
        begin
            r.val = {a.val[29:0], 2'b00};
            r.cnt = a.cnt - 5'd1;
            if (sh >= trial)
            begin
                r.rem = diff[16:0];
                r.root = {a.root[14:0], 1'b1};
            end
            else
            begin
                r.rem = sh[16:0];
                r.root = {a.root[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/svu_cell.sv @@
// One cell of the arithmetic chain: a division step on every lane and a root step.
// Depends on svu_pkg.
module svu_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  svu_pkg::bundle_t din,
    output svu_pkg::bundle_t dout
);
    import svu_pkg::*;

    logic    valid_reg;
    bundle_t data_reg;
    bundle_t data_next;

    always_comb
    begin
        data_next = din;
        for (int i = 0; i < LANES; i++)
        begin
            data_next.lane[i] = div_step(din.lane[i]);
        end
        data_next.rt = root_step(din.rt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        dout = data_reg;
        dout.valid = valid_reg;
    end

endmodule

@@ rtl/svu_chain.sv @@
// Row of STEPS identical cells, each passing its bundle to the next every cycle while en is high.
// Depends on svu_pkg and svu_cell.
module svu_chain (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  svu_pkg::bundle_t din,
    output svu_pkg::bundle_t dout
);
    import svu_pkg::*;

    bundle_t link [0:STEPS];

    assign link[0] = din;

    for (genvar g = 0; g < STEPS; g++)
    begin : g_cell
        svu_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .din  (link[g]),
            .dout (link[g+1])
        );
    end

    assign dout = link[STEPS];

endmodule

@@ rtl/sky_cloud_vertex_uv_unit.sv @@
// Top level of the sky cloud vertex UV unit: config registers, glue stages, output skid.
// Depends on svu_pkg and svu_chain.
//
// Takes one vertex transaction per clock while s_axis_tready is high and returns one result
// transaction per vertex, in order. Each vertex passes through three chains of 48 one-bit
// division cells (ray distance and root, reach clamp and opacity, texture coordinates)
// plus eight glue and output stages. A two-entry output buffer keeps the input side
// accepting while one result waits. Configuration is to be written over the APB port
// only while no vertex is in flight; the block itself does not enforce this.
module sky_cloud_vertex_uv_unit (
    input  logic         clk,
    input  logic         rst_n,
    // eye_x[31:0], eye_y[63:32], eye_z[95:64], dir_x[111:96], dir_y[127:112],
    // dir_z[143:128], time_seconds[175:144]
    input  logic [175:0] s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // active[0], opacity[17:1], tex_s[49:18], tex_t[81:50], zero[87:82]
    output logic [87:0]  m_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import svu_pkg::*;

    typedef struct packed {
        logic               active;
        logic [31:0]        dy;
        logic [14:0]        vy;
        logic signed [15:0] dx;
        logic signed [15:0] dz;
        logic signed [15:0] dyr;
        logic [30:0]        sqx;
        logic [30:0]        sqz;
        logic               ex_neg;
        logic [21:0]        ex_hi;
        logic [9:0]         ex_lo;
        logic               ez_neg;
        logic [21:0]        ez_hi;
        logic [9:0]         ez_lo;
        logic [35:0]        t15;
    } p1_t;

    typedef struct packed {
        logic               active;
        logic [16:0]        op;
        logic signed [15:0] dx;
        logic signed [15:0] dz;
        logic [36:0]        df;
        logic signed [24:0] rs;
        logic signed [24:0] rz;
        logic [29:0]        rt;
    } sa_t;

    typedef struct packed {
        logic               active;
        logic [16:0]        op;
        logic signed [24:0] rs;
        logic signed [24:0] rz;
        logic [29:0]        rt;
        logic signed [38:0] ox;
        logic signed [38:0] oz;
    } sb_t;

    typedef struct packed {
        logic               active;
        logic [16:0]        op;
        logic signed [41:0] ns;
        logic signed [41:0] nt;
    } sc_t;

    typedef struct packed {
        logic [31:0] tex_t;
        logic [31:0] tex_s;
        logic [16:0] opacity;
        logic        active;
    } out_t;

    function automatic logic [31:0] sat_q(logic neg, logic [NUM_W-1:0] q);
        logic [31:0] r;
        if (!neg)
        begin
            r = (q > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
        else
        begin
            r = (q > 48'h8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
        end
        return r;
    endfunction

    // configuration
    logic               enable_reg;
    logic signed [31:0] altitude_reg;
    logic [10:0]        tile_w_reg;
    logic [10:0]        tile_h_reg;
    logic               cfg_wr;
    logic [13:0]        tile_w5;
    logic [13:0]        tile_h5;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign tile_w5 = {1'b0, tile_w_reg, 2'b00} + {3'b000, tile_w_reg};
    assign tile_h5 = {1'b0, tile_h_reg, 2'b00} + {3'b000, tile_h_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            altitude_reg <= 32'sd0;
            tile_w_reg   <= 11'd1;
            tile_h_reg   <= 11'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ENABLE:   enable_reg   <= pwdata[0];
                REG_ALTITUDE: altitude_reg <= pwdata;
                REG_TILE_W:   tile_w_reg   <= pwdata[10:0];
                REG_TILE_H:   tile_h_reg   <= pwdata[10:0];
                default:      enable_reg   <= enable_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ENABLE:   prdata = {31'd0, enable_reg};
            REG_ALTITUDE: prdata = altitude_reg;
            REG_TILE_W:   prdata = {21'd0, tile_w_reg};
            REG_TILE_H:   prdata = {21'd0, tile_h_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // flow control
    logic en;
    logic m_valid_reg;
    logic m_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    out_t m_data_reg;
    out_t skid_data_reg;
    out_t p_data;
    logic pop;
    logic push;
    logic load_m_p;
    logic load_m_skid;
    logic load_skid;

    assign en = !skid_valid_reg;
    assign s_axis_tready = en;

    // input stage
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [31:0]        time_s;
    logic signed [32:0] rise;
    logic signed [31:0] px;
    logic signed [31:0] pz;
    logic [31:0]        ex_abs;
    logic [31:0]        ez_abs;
    p1_t                p1_next;
    p1_t                p1_reg;
    logic               p1_valid_reg;

    assign eye_x  = s_axis_tdata[31:0];
    assign eye_y  = s_axis_tdata[63:32];
    assign eye_z  = s_axis_tdata[95:64];
    assign dir_x  = s_axis_tdata[111:96];
    assign dir_y  = s_axis_tdata[127:112];
    assign dir_z  = s_axis_tdata[143:128];
    assign time_s = s_axis_tdata[175:144];

    always_comb
    begin
        rise = {altitude_reg[31], altitude_reg} - {eye_y[31], eye_y};
        px = dir_x * dir_x;
        pz = dir_z * dir_z;
        ex_abs = eye_x[31] ? (32'd0 - eye_x) : eye_x;
        ez_abs = eye_z[31] ? (32'd0 - eye_z) : eye_z;
        p1_next.active = enable_reg && (tile_w_reg != 11'd0) && (tile_h_reg != 11'd0);
        p1_next.dy = (rise < 33'sd1600) ? MIN_RISE : rise[31:0];
        p1_next.vy = (dir_y < 16'sd16) ? MIN_DIR_Y : dir_y[14:0];
        p1_next.dx = dir_x;
        p1_next.dz = dir_z;
        p1_next.dyr = dir_y;
        p1_next.sqx = px[30:0];
        p1_next.sqz = pz[30:0];
        p1_next.ex_neg = eye_x[31];
        p1_next.ex_hi = ex_abs[31:10];
        p1_next.ex_lo = ex_abs[9:0];
        p1_next.ez_neg = eye_z[31];
        p1_next.ez_hi = ez_abs[31:10];
        p1_next.ez_lo = ez_abs[9:0];
        p1_next.t15 = {time_s, 4'b0000} - {4'b0000, time_s};
    end

    // chain 1: ray distance, tile remainders, time remainder, horizontal length
    bundle_t b1_next;
    bundle_t b1_reg;
    bundle_t c1;
    side1_t  s1n;

    always_comb
    begin
        b1_next = '0;
        b1_next.valid = p1_valid_reg;
        b1_next.lane[0].num = {2'b00, p1_reg.dy, 14'd0};
        b1_next.lane[0].den = {1'b0, p1_reg.vy};
        b1_next.lane[1].num = {26'd0, p1_reg.ex_hi};
        b1_next.lane[1].den = {2'b00, tile_w5};
        b1_next.lane[2].num = {26'd0, p1_reg.ez_hi};
        b1_next.lane[2].den = {2'b00, tile_h5};
        b1_next.lane[3].num = {31'd0, p1_reg.t15[35:19]};
        b1_next.lane[3].den = {5'd0, tile_h_reg};
        b1_next.rt.cnt = ROOT_STEPS;
        b1_next.rt.val = {1'b0, p1_reg.sqx} + {1'b0, p1_reg.sqz};
        s1n.active = p1_reg.active;
        s1n.dx = p1_reg.dx;
        s1n.dz = p1_reg.dz;
        s1n.dyr = p1_reg.dyr;
        s1n.ex_neg = p1_reg.ex_neg;
        s1n.ex_lo = p1_reg.ex_lo;
        s1n.ez_neg = p1_reg.ez_neg;
        s1n.ez_lo = p1_reg.ez_lo;
        s1n.t15_lo = p1_reg.t15[18:0];
        b1_next.side[$bits(side1_t)-1:0] = s1n;
    end

    svu_chain u_chain1 (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .din  (b1_reg),
        .dout (c1)
    );

    // chain 2: reach limit quotient and opacity quotient
    side1_t      s1;
    side2_t      s2n;
    bundle_t     b2_next;
    bundle_t     b2_reg;
    bundle_t     c2;
    logic [23:0] rs_mag;
    logic [23:0] rz_mag;

    always_comb
    begin
        s1 = side1_t'(c1.side[$bits(side1_t)-1:0]);
        rs_mag = {c1.lane[1].rem[13:0], s1.ex_lo};
        rz_mag = {c1.lane[2].rem[13:0], s1.ez_lo};
        s2n.active = s1.active;
        s2n.dx = s1.dx;
        s2n.dz = s1.dz;
        s2n.dyr = s1.dyr;
        s2n.h = c1.rt.root;
        s2n.d = c1.lane[0].quo[42:0];
        s2n.rs = s1.ex_neg ? -$signed({1'b0, rs_mag}) : $signed({1'b0, rs_mag});
        s2n.rz = s1.ez_neg ? -$signed({1'b0, rz_mag}) : $signed({1'b0, rz_mag});
        s2n.rt = {c1.lane[3].rem[10:0], s1.t15_lo};
        b2_next = '0;
        b2_next.valid = c1.valid;
        b2_next.lane[0].num = {11'd0, REACH_LIMIT};
        b2_next.lane[0].den = c1.rt.root;
        b2_next.lane[1].num = (s1.dyr > 16'sd0) ? {16'd0, s1.dyr[14:0], 17'd0} : 48'd0;
        b2_next.lane[1].den = c1.rt.root;
        b2_next.side = s2n;
    end

    svu_chain u_chain2 (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .din  (b2_reg),
        .dout (c2)
    );

    // glue: clamp, offsets, numerators
    side2_t             s2;
    sa_t                sa_next;
    sa_t                sa_reg;
    logic               sa_valid_reg;
    sb_t                sb_next;
    sb_t                sb_reg;
    logic               sb_valid_reg;
    sc_t                sc_next;
    sc_t                sc_reg;
    logic               sc_valid_reg;
    logic signed [53:0] mx;
    logic signed [53:0] mz;

    always_comb
    begin
        s2 = c2.side;
        sa_next.active = s2.active;
        sa_next.dx = s2.dx;
        sa_next.dz = s2.dz;
        sa_next.rs = s2.rs;
        sa_next.rz = s2.rz;
        sa_next.rt = s2.rt;
        if ((s2.h != 16'd0) && ({5'd0, s2.d} > c2.lane[0].quo))
        begin
            sa_next.df = c2.lane[0].quo[36:0];
        end
        else
        begin
            sa_next.df = s2.d[36:0];
        end
        if (s2.h == 16'd0)
        begin
            sa_next.op = (s2.dyr > 16'sd0) ? ONE_Q16 : 17'd0;
        end
        else if (s2.dyr <= 16'sd0)
        begin
            sa_next.op = 17'd0;
        end
        else
        begin
            sa_next.op = (c2.lane[1].quo > 48'd65536) ? ONE_Q16 : c2.lane[1].quo[16:0];
        end
    end

    always_comb
    begin
        mx = $signed({1'b0, sa_reg.df}) * sa_reg.dx;
        mz = $signed({1'b0, sa_reg.df}) * sa_reg.dz;
        sb_next.active = sa_reg.active;
        sb_next.op = sa_reg.op;
        sb_next.rs = sa_reg.rs;
        sb_next.rz = sa_reg.rz;
        sb_next.rt = sa_reg.rt;
        sb_next.ox = mx[38:0];
        sb_next.oz = mz[38:0];
    end

    always_comb
    begin
        sc_next.active = sb_reg.active;
        sc_next.op = sb_reg.op;
        sc_next.ns = {{3{sb_reg.rs[24]}}, sb_reg.rs, 14'd0}
                   + {{3{sb_reg.ox[38]}}, sb_reg.ox};
        sc_next.nt = {{3{sb_reg.rz[24]}}, sb_reg.rz, 14'd0}
                   + {{3{sb_reg.oz[38]}}, sb_reg.oz}
                   + {5'd0, sb_reg.rt, 7'd0}
                   + {7'd0, sb_reg.rt, 5'd0};
    end

    // chain 3: texture coordinate quotients
    bundle_t     b3_next;
    bundle_t     b3_reg;
    bundle_t     c3;
    side3_t      s3n;
    logic [41:0] ns_mag;
    logic [41:0] nt_mag;

    always_comb
    begin
        ns_mag = sc_reg.ns[41] ? (~sc_reg.ns + 42'd1) : sc_reg.ns;
        nt_mag = sc_reg.nt[41] ? (~sc_reg.nt + 42'd1) : sc_reg.nt;
        s3n.active = sc_reg.active;
        s3n.op = sc_reg.op;
        s3n.s_neg = sc_reg.ns[41];
        s3n.t_neg = sc_reg.nt[41];
        b3_next = '0;
        b3_next.valid = sc_valid_reg;
        b3_next.lane[0].num = {14'd0, ns_mag[41:8]};
        b3_next.lane[0].den = {2'b00, tile_w5};
        b3_next.lane[1].num = {14'd0, nt_mag[41:8]};
        b3_next.lane[1].den = {2'b00, tile_h5};
        b3_next.side[$bits(side3_t)-1:0] = s3n;
    end

    svu_chain u_chain3 (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .din  (b3_reg),
        .dout (c3)
    );

    side3_t s3;

    always_comb
    begin
        s3 = side3_t'(c3.side[$bits(side3_t)-1:0]);
        if (s3.active)
        begin
            p_data.active = 1'b1;
            p_data.opacity = s3.op;
            p_data.tex_s = sat_q(s3.s_neg, c3.lane[0].quo);
            p_data.tex_t = sat_q(s3.t_neg, c3.lane[1].quo);
        end
        else
        begin
            p_data = '0;
        end
    end

    // stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            sa_valid_reg <= 1'b0;
            sb_valid_reg <= 1'b0;
            sc_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= s_axis_tvalid;
            sa_valid_reg <= c2.valid;
            sb_valid_reg <= sa_valid_reg;
            sc_valid_reg <= sb_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= p1_next;
            b1_reg <= b1_next;
            b2_reg <= b2_next;
            sa_reg <= sa_next;
            sb_reg <= sb_next;
            sc_reg <= sc_next;
            b3_reg <= b3_next;
        end
    end

    // output register and skid entry
    always_comb
    begin
        pop = m_valid_reg && m_axis_tready;
        push = en && c3.valid;
        m_valid_next = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_m_p = 1'b0;
        load_m_skid = 1'b0;
        load_skid = 1'b0;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                load_m_skid = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!m_valid_reg || pop)
            begin
                load_m_p = 1'b1;
                m_valid_next = 1'b1;
            end
            else
            begin
                load_skid = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_m_p)
        begin
            m_data_reg <= p_data;
        end
        else if (load_m_skid)
        begin
            m_data_reg <= skid_data_reg;
        end
        if (load_skid)
        begin
            skid_data_reg <= p_data;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = {6'd0, m_data_reg};

endmodule

@@ rtl/svu_checker.sv @@
// Port-level checks for the sky cloud vertex UV unit, bound to the top level.
// Depends on sky_cloud_vertex_uv_unit.
module svu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transaction dropped while stalled");

    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[81:1] == 81'd0)
        else $error("inactive result carries nonzero fields");

    a_opacity_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[17:1] <= 17'd65536)
        else $error("opacity above one");

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

endmodule

bind sky_cloud_vertex_uv_unit svu_checker u_svu_checker (.*);
